/* hw/rtl/ctl_pkg.sv */
// shared constants, types and character class functions of the token lexer
package ctl_pkg;

	localparam int unsigned DEF_LINE_BITS   = 20;
	localparam int unsigned DEF_COLUMN_BITS = 16;
	localparam int unsigned DEF_LENGTH_BITS = 16;

	// most tokens one text byte can close: previous token, one-byte token or flush, end
	localparam int unsigned MAX_RES = 3;

	typedef enum logic [3:0] {
		TOK_UNKNOWN  = 4'd0,
		TOK_IDENT    = 4'd1,
		TOK_NUMBER   = 4'd2,
		TOK_STRING   = 4'd3,
		TOK_OPERATOR = 4'd4,
		TOK_DELIM    = 4'd5,
		TOK_NEWLINE  = 4'd6,
		TOK_SPACE    = 4'd7,
		TOK_COMMENT  = 4'd8,
		TOK_END      = 4'd9
	} tok_type_t;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_POINT  = 8'h2e;
	localparam logic [7:0] CH_UNDER  = 8'h5f;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_PLUS   = 8'h2b;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
	endfunction

	function automatic logic is_word(input logic [7:0] b);
		return is_alpha(b) || is_digit(b) || (b == CH_UNDER);
	endfunction

	// space, tab, vertical tab, form feed, carriage return
	function automatic logic is_blank(input logic [7:0] b);
		return (b == 8'h20) || (b == 8'h09) || (b == 8'h0b) || (b == 8'h0c) || (b == 8'h0d);
	endfunction

	function automatic logic is_op(input logic [7:0] b);
		return (b == CH_STAR) || (b == 8'h3d) || (b == 8'h3c) || (b == 8'h3e) ||
			(b == 8'h21) || (b == 8'h26) || (b == 8'h7c) || (b == 8'h5e) ||
			(b == 8'h25) || (b == 8'h7e);
	endfunction

	function automatic logic is_delim(input logic [7:0] b);
		return (b == 8'h28) || (b == 8'h29) || (b == 8'h7b) || (b == 8'h7d) ||
			(b == 8'h5b) || (b == 8'h5d) || (b == 8'h3b) || (b == 8'h3a) || (b == 8'h2c);
	endfunction

endpackage

/* hw/rtl/ctl_if.sv */
// valid/ready channel interfaces for text bytes and tokens
interface ctl_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ctl_tok_if #(
	parameter int unsigned LINE_BITS   = 20,
	parameter int unsigned COLUMN_BITS = 16,
	parameter int unsigned LENGTH_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [3:0]             token_type;
	logic [LINE_BITS-1:0]   start_line;
	logic [COLUMN_BITS-1:0] start_column;
	logic [LENGTH_BITS-1:0] token_length;
	logic                   is_last;

	modport source (output valid, output token_type, output start_line, output start_column,
		output token_length, output is_last, input ready);
	modport sink (input valid, input token_type, input start_line, input start_column,
		input token_length, input is_last, output ready);
endinterface

/* hw/rtl/ctl_lexer_core.sv */
// lexer state and the combinational step that classifies one byte and closes tokens
module ctl_lexer_core #(
	parameter int unsigned LINE_BITS   = 20,
	parameter int unsigned COLUMN_BITS = 16,
	parameter int unsigned LENGTH_BITS = 16,
	localparam int unsigned RES_W = 4 + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [7:0]                  text_byte,
	input  logic                        end_of_text,
	output logic [1:0]                  res_cnt,
	output logic [ctl_pkg::MAX_RES-1:0][RES_W-1:0] res
);
	import ctl_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE, M_SPACE, M_LINECMT, M_SLASH, M_BLOCK, M_STRING, M_NUMBER, M_IDENT
	} mode_t;

	localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
	localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);
	localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);

	mode_t                  mode_q, mode_d;
	logic [7:0]             quote_q, quote_d;
	logic                   esc_q, esc_d;
	logic                   digit_q, digit_d;
	logic                   point_q, point_d;
	logic                   star_q, star_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [COLUMN_BITS-1:0] col_q, col_d;
	logic [LINE_BITS-1:0]   tline_q, tline_d;
	logic [COLUMN_BITS-1:0] tcol_q, tcol_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;

	always_comb begin
		logic       start;
		logic       cls;
		tok_type_t  ctype;
		logic [1:0] n;
		mode_d  = mode_q;
		quote_d = quote_q;
		esc_d   = esc_q;
		digit_d = digit_q;
		point_d = point_q;
		star_d  = star_q;
		line_d  = line_q;
		col_d   = col_q;
		tline_d = tline_q;
		tcol_d  = tcol_q;
		len_d   = len_q;
		start   = 1'b0;
		cls     = 1'b0;
		ctype   = TOK_UNKNOWN;
		n       = 2'd0;
		res     = '0;

		// continue or close the open token
		case (mode_q)
			M_SPACE: begin
				if (is_blank(text_byte)) begin
					if (len_d != '1) len_d = len_d + LEN_ONE;
				end else begin
					cls = 1'b1; ctype = TOK_SPACE; start = 1'b1;
				end
			end
			M_LINECMT: begin
				if (text_byte != CH_NL) begin
					if (len_d != '1) len_d = len_d + LEN_ONE;
				end else begin
					cls = 1'b1; ctype = TOK_COMMENT; start = 1'b1;
				end
			end
			M_SLASH: begin
				if (text_byte == CH_SLASH) begin
					if (len_d != '1) len_d = len_d + LEN_ONE;
					mode_d = M_LINECMT;
				end else if (text_byte == CH_STAR) begin
					if (len_d != '1) len_d = len_d + LEN_ONE;
					mode_d = M_BLOCK;
					star_d = 1'b0;
				end else begin
					cls = 1'b1; ctype = TOK_OPERATOR; start = 1'b1;
				end
			end
			M_BLOCK: begin
				if (len_d != '1) len_d = len_d + LEN_ONE;
				if (star_q && (text_byte == CH_SLASH)) begin
					cls = 1'b1; ctype = TOK_COMMENT;
				end else begin
					star_d = (text_byte == CH_STAR);
				end
			end
			M_STRING: begin
				if (len_d != '1) len_d = len_d + LEN_ONE;
				if (esc_q) esc_d = 1'b0;
				else if (text_byte == CH_BSLASH) esc_d = 1'b1;
				else if (text_byte == quote_q) begin
					cls = 1'b1; ctype = TOK_STRING;
				end
			end
			M_NUMBER: begin
				if (is_digit(text_byte)) begin
					digit_d = 1'b1;
					if (len_d != '1) len_d = len_d + LEN_ONE;
				end else if ((text_byte == CH_POINT) && !point_q) begin
					point_d = 1'b1;
					if (len_d != '1) len_d = len_d + LEN_ONE;
				end else begin
					cls = 1'b1; ctype = digit_q ? TOK_NUMBER : TOK_UNKNOWN; start = 1'b1;
				end
			end
			M_IDENT: begin
				if (is_word(text_byte)) begin
					if (len_d != '1) len_d = len_d + LEN_ONE;
				end else begin
					cls = 1'b1; ctype = TOK_IDENT; start = 1'b1;
				end
			end
			default: start = 1'b1;
		endcase

		if (cls) begin
			res[n] = {4'(ctype), tline_d, tcol_d, len_d, 1'b0};
			n = n + 2'd1;
			mode_d = M_IDLE;
		end

		// open a new token with this byte
		if (start) begin
			tline_d = line_q;
			tcol_d  = col_q;
			len_d   = LEN_ONE;
			cls     = 1'b0;
			mode_d  = M_IDLE;
			if (text_byte == CH_NL) begin
				cls = 1'b1; ctype = TOK_NEWLINE;
			end else if (is_blank(text_byte)) begin
				mode_d = M_SPACE;
			end else if (text_byte == CH_HASH) begin
				mode_d = M_LINECMT;
			end else if (text_byte == CH_SLASH) begin
				mode_d = M_SLASH;
			end else if ((text_byte == CH_DQUOTE) || (text_byte == CH_SQUOTE)) begin
				mode_d  = M_STRING;
				quote_d = text_byte;
				esc_d   = 1'b0;
			end else if (is_digit(text_byte) || (text_byte == CH_PLUS) ||
				(text_byte == CH_MINUS) || (text_byte == CH_POINT)) begin
				mode_d  = M_NUMBER;
				digit_d = is_digit(text_byte);
				point_d = (text_byte == CH_POINT);
			end else if (is_alpha(text_byte) || (text_byte == CH_UNDER)) begin
				mode_d = M_IDENT;
			end else if (is_op(text_byte)) begin
				cls = 1'b1; ctype = TOK_OPERATOR;
			end else if (is_delim(text_byte)) begin
				cls = 1'b1; ctype = TOK_DELIM;
			end else begin
				cls = 1'b1; ctype = TOK_UNKNOWN;
			end
			if (cls) begin
				res[n] = {4'(ctype), tline_d, tcol_d, len_d, 1'b0};
				n = n + 2'd1;
			end
		end

		// position after this byte
		if (text_byte == CH_NL) begin
			if (line_d != '1) line_d = line_d + LINE_ONE;
			col_d = COL_ONE;
		end else if (col_d != '1) begin
			col_d = col_d + COL_ONE;
		end

		if (end_of_text) begin
			cls = 1'b1;
			case (mode_d)
				M_SPACE:   ctype = TOK_SPACE;
				M_LINECMT: ctype = TOK_COMMENT;
				M_SLASH:   ctype = TOK_OPERATOR;
				M_BLOCK:   ctype = TOK_COMMENT;
				M_STRING:  ctype = TOK_UNKNOWN;
				M_NUMBER:  ctype = digit_d ? TOK_NUMBER : TOK_UNKNOWN;
				M_IDENT:   ctype = TOK_IDENT;
				default:   cls = 1'b0;
			endcase
			if (cls) begin
				res[n] = {4'(ctype), tline_d, tcol_d, len_d, 1'b0};
				n = n + 2'd1;
			end
			res[n] = {4'(TOK_END), line_d, col_d, {LENGTH_BITS{1'b0}}, 1'b1};
			n = n + 2'd1;
			// back to the reset state for the next text
			mode_d  = M_IDLE;
			quote_d = '0;
			esc_d   = 1'b0;
			digit_d = 1'b0;
			point_d = 1'b0;
			star_d  = 1'b0;
			line_d  = LINE_ONE;
			col_d   = COL_ONE;
			tline_d = LINE_ONE;
			tcol_d  = COL_ONE;
			len_d   = '0;
		end
		res_cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			quote_q <= '0;
			esc_q   <= 1'b0;
			digit_q <= 1'b0;
			point_q <= 1'b0;
			star_q  <= 1'b0;
			line_q  <= LINE_ONE;
			col_q   <= COL_ONE;
			tline_q <= LINE_ONE;
			tcol_q  <= COL_ONE;
			len_q   <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			quote_q <= quote_d;
			esc_q   <= esc_d;
			digit_q <= digit_d;
			point_q <= point_d;
			star_q  <= star_d;
			line_q  <= line_d;
			col_q   <= col_d;
			tline_q <= tline_d;
			tcol_q  <= tcol_d;
			len_q   <= len_d;
		end
	end

endmodule

/* hw/rtl/ctl_result_buf.sv */
// small result register bank that hands out the tokens of one byte in order
module ctl_result_buf #(
	parameter int unsigned LINE_BITS   = 20,
	parameter int unsigned COLUMN_BITS = 16,
	parameter int unsigned LENGTH_BITS = 16,
	localparam int unsigned RES_W = 4 + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  logic [1:0]                             load_cnt,
	input  logic [ctl_pkg::MAX_RES-1:0][RES_W-1:0] load_data,
	output logic                                   can_load,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [RES_W-1:0]                       out_data
);
	import ctl_pkg::*;

	logic [MAX_RES-1:0][RES_W-1:0] data_q;
	logic [1:0]                    count_q;
	logic [1:0]                    head_q;
	logic                          pop;

	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	// free once the last held token leaves this cycle
	assign can_load  = (count_q == 2'd0) || ((count_q == 2'd1) && out_ready);
	assign out_data  = data_q[head_q];

	always_ff @(posedge clk) begin
		if (load) data_q <= load_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			head_q  <= 2'd0;
		end else if (load) begin
			count_q <= load_cnt;
			head_q  <= 2'd0;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
			head_q  <= (count_q == 2'd1) ? 2'd0 : head_q + 2'd1;
		end
	end

endmodule

/* hw/rtl/c_style_token_lexer_unit.sv */
// C-style token lexer: byte request in, token requests out
// Takes one text byte per cycle through an input register while the result bank can load;
// the lexer step classifies the registered byte and in the same cycle loads the tokens it
// closes (up to three: the previous token, a one-byte token or the final flush, and the end
// token) into a result bank. The next byte is taken only once the bank is empty or sending
// its last token; the bank sends one token request per cycle while tokens.ready is high.
// Line, column and length counters saturate at all ones; after the end token all counters
// and the lexer mode return to their reset values for the next text.
module c_style_token_lexer_unit #(
	parameter int unsigned LINE_BITS   = ctl_pkg::DEF_LINE_BITS,
	parameter int unsigned COLUMN_BITS = ctl_pkg::DEF_COLUMN_BITS,
	parameter int unsigned LENGTH_BITS = ctl_pkg::DEF_LENGTH_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	ctl_char_if.sink   chars,
	ctl_tok_if.source  tokens
);
	import ctl_pkg::*;

	localparam int unsigned RES_W = 4 + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 1;

	logic                          v_s1;
	logic [7:0]                    byte_s1;
	logic                          last_s1;
	logic                          fire;
	logic                          can_load;
	logic [1:0]                    res_cnt;
	logic [MAX_RES-1:0][RES_W-1:0] res;
	logic [RES_W-1:0]              out_data;

	assign fire        = v_s1 && can_load;
	assign chars.ready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (chars.ready) begin
			v_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			byte_s1 <= chars.text_byte;
			last_s1 <= chars.end_of_text;
		end
	end

	ctl_lexer_core #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.text_byte   (byte_s1),
		.end_of_text (last_s1),
		.res_cnt     (res_cnt),
		.res         (res)
	);

	ctl_result_buf #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.load_cnt  (res_cnt),
		.load_data (res),
		.can_load  (can_load),
		.out_valid (tokens.valid),
		.out_ready (tokens.ready),
		.out_data  (out_data)
	);

	assign {tokens.token_type, tokens.start_line, tokens.start_column,
		tokens.token_length, tokens.is_last} = out_data;

endmodule

/* verif/tb_c_style_token_lexer_unit.sv */
// self-checking testbench of the c-style token lexer: directed table and random texts
`timescale 1ns / 100ps

module tb_c_style_token_lexer_unit;
	import ctl_pkg::*;

	localparam int unsigned LINE_W = DEF_LINE_BITS;
	localparam int unsigned COL_W  = DEF_COLUMN_BITS;
	localparam int unsigned LEN_W  = DEF_LENGTH_BITS;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned DRAIN_CYCLES  = 16;
	localparam int unsigned RANDOM_ITEMS  = 125;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned HOLD_AFTER    = 40;
	localparam int unsigned N_DIRECTED    = 27;

	typedef struct packed {
		tok_type_t        kind;
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0]  col;
		logic [LEN_W-1:0]  len;
		logic              last;
	} token_rec_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eot;
		logic       typed;
		token_rec_t want;
	} stim_row_t;

	typedef enum logic [2:0] {
		MODE_IDLE, MODE_SPACE, MODE_LINE_CMT, MODE_SLASH,
		MODE_BLOCK, MODE_STRING, MODE_NUMBER, MODE_IDENT
	} lex_mode_e;

	typedef enum logic [3:0] {
		CL_NEWLINE, CL_BLANK, CL_HASH, CL_SLASH, CL_QUOTE, CL_DIGIT,
		CL_SIGN, CL_POINT, CL_LETTER, CL_OPER, CL_DELIM, CL_OTHER
	} char_class_e;

	localparam token_rec_t NO_TOKEN = '0;

	logic clk;
	logic arst_n;

	ctl_char_if chars ();
	ctl_tok_if #(.LINE_BITS(LINE_W), .COLUMN_BITS(COL_W), .LENGTH_BITS(LEN_W)) tokens ();

	c_style_token_lexer_unit #(
		.LINE_BITS(LINE_W),
		.COLUMN_BITS(COL_W),
		.LENGTH_BITS(LEN_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.tokens(tokens)
	);

	// lexer state kept by the predictor
	lex_mode_e         lex_mode;
	logic [7:0]        quote_ch;
	bit                escaped;
	bit                got_digit;
	bit                got_point;
	bit                star_prev;
	logic [LINE_W-1:0] line_no;
	logic [COL_W-1:0]  col_no;
	logic [LINE_W-1:0] tok_line;
	logic [COL_W-1:0]  tok_col;
	logic [LEN_W-1:0]  tok_len;

	token_rec_t  fresh_tokens[$];
	token_rec_t  expected_tokens[$];
	logic [7:0]  frag[$];

	bit          idle_on = 1'b1;
	int unsigned tokens_seen;
	int unsigned hold_left;
	bit          held_once;
	int unsigned cycle_count;
	int          mismatches;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{CH_NL,     1'b0, 1'b1, '{TOK_NEWLINE,  20'd1, 16'd1, 16'd1, 1'b0}},
		'{8'h00,     1'b0, 1'b1, '{TOK_UNKNOWN,  20'd2, 16'd1, 16'd1, 1'b0}},
		'{8'hff,     1'b0, 1'b1, '{TOK_UNKNOWN,  20'd2, 16'd2, 16'd1, 1'b0}},
		'{"(",       1'b0, 1'b1, '{TOK_DELIM,    20'd2, 16'd3, 16'd1, 1'b0}},
		'{CH_STAR,   1'b0, 1'b1, '{TOK_OPERATOR, 20'd2, 16'd4, 16'd1, 1'b0}},
		'{8'h09,     1'b0, 1'b0, NO_TOKEN},
		'{8'h20,     1'b0, 1'b0, NO_TOKEN},
		'{"a",       1'b0, 1'b0, NO_TOKEN},
		'{CH_UNDER,  1'b0, 1'b0, NO_TOKEN},
		'{CH_MINUS,  1'b0, 1'b0, NO_TOKEN},
		'{CH_POINT,  1'b0, 1'b0, NO_TOKEN},
		'{"9",       1'b0, 1'b0, NO_TOKEN},
		'{CH_POINT,  1'b0, 1'b0, NO_TOKEN},
		'{CH_PLUS,   1'b0, 1'b0, NO_TOKEN},
		'{CH_SQUOTE, 1'b0, 1'b0, NO_TOKEN},
		'{CH_BSLASH, 1'b0, 1'b0, NO_TOKEN},
		'{CH_SQUOTE, 1'b0, 1'b0, NO_TOKEN},
		'{CH_SQUOTE, 1'b0, 1'b0, NO_TOKEN},
		'{CH_SLASH,  1'b0, 1'b0, NO_TOKEN},
		'{"x",       1'b0, 1'b0, NO_TOKEN},
		'{CH_SLASH,  1'b0, 1'b0, NO_TOKEN},
		'{CH_STAR,   1'b0, 1'b0, NO_TOKEN},
		'{CH_STAR,   1'b0, 1'b0, NO_TOKEN},
		'{CH_SLASH,  1'b0, 1'b0, NO_TOKEN},
		'{CH_HASH,   1'b0, 1'b0, NO_TOKEN},
		'{CH_NL,     1'b0, 1'b0, NO_TOKEN},
		'{CH_DQUOTE, 1'b1, 1'b0, NO_TOKEN}
	};

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic char_class_e classify(input logic [7:0] b);
		case (b)
			CH_NL: return CL_NEWLINE;
			8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d: return CL_BLANK;
			CH_HASH: return CL_HASH;
			CH_SLASH: return CL_SLASH;
			CH_DQUOTE, CH_SQUOTE: return CL_QUOTE;
			CH_PLUS, CH_MINUS: return CL_SIGN;
			CH_POINT: return CL_POINT;
			CH_UNDER: return CL_LETTER;
			"*", "=", "<", ">", "!", "&", "|", "^", "%", "~": return CL_OPER;
			"(", ")", "{", "}", "[", "]", ";", ":", ",": return CL_DELIM;
			default: ;
		endcase
		if (b >= "0" && b <= "9")
			return CL_DIGIT;
		// folding bit 5 maps upper case onto lower case
		if ((b | 8'h20) >= "a" && (b | 8'h20) <= "z")
			return CL_LETTER;
		return CL_OTHER;
	endfunction

	function automatic void restart_lexer();
		lex_mode  = MODE_IDLE;
		quote_ch  = '0;
		escaped   = 1'b0;
		got_digit = 1'b0;
		got_point = 1'b0;
		star_prev = 1'b0;
		line_no   = LINE_W'(1);
		col_no    = COL_W'(1);
		tok_line  = LINE_W'(1);
		tok_col   = COL_W'(1);
		tok_len   = '0;
	endfunction

	function automatic void emit(input tok_type_t kind, input logic [LINE_W-1:0] ln,
			input logic [COL_W-1:0] cl, input logic [LEN_W-1:0] n, input logic last);
		fresh_tokens.push_back('{kind, ln, cl, n, last});
	endfunction

	function automatic void close_token(input tok_type_t kind);
		emit(kind, tok_line, tok_col, tok_len, 1'b0);
		lex_mode = MODE_IDLE;
	endfunction

	function automatic void grow_token();
		if (tok_len != '1)
			tok_len = tok_len + 1'b1;
	endfunction

	function automatic void open_token(input logic [7:0] b, input char_class_e cls);
		tok_line = line_no;
		tok_col  = col_no;
		tok_len  = LEN_W'(1);
		case (cls)
			CL_NEWLINE: close_token(TOK_NEWLINE);
			CL_BLANK: lex_mode = MODE_SPACE;
			CL_HASH: lex_mode = MODE_LINE_CMT;
			CL_SLASH: lex_mode = MODE_SLASH;
			CL_QUOTE: begin
				lex_mode = MODE_STRING;
				quote_ch = b;
				escaped  = 1'b0;
			end
			CL_DIGIT, CL_SIGN, CL_POINT: begin
				lex_mode  = MODE_NUMBER;
				got_digit = (cls == CL_DIGIT);
				got_point = (cls == CL_POINT);
			end
			CL_LETTER: lex_mode = MODE_IDENT;
			CL_OPER: close_token(TOK_OPERATOR);
			CL_DELIM: close_token(TOK_DELIM);
			default: close_token(TOK_UNKNOWN);
		endcase
	endfunction

	// tokens closed by one text byte land in fresh_tokens
	function automatic void lex_byte(input logic [7:0] b, input logic eot);
		char_class_e cls;
		bit taken;
		cls   = classify(b);
		taken = 1'b0;
		case (lex_mode)
			MODE_SPACE: begin
				if (cls == CL_BLANK) begin
					grow_token();
					taken = 1'b1;
				end else
					close_token(TOK_SPACE);
			end
			MODE_LINE_CMT: begin
				if (cls != CL_NEWLINE) begin
					grow_token();
					taken = 1'b1;
				end else
					close_token(TOK_COMMENT);
			end
			MODE_SLASH: begin
				if (b == CH_SLASH) begin
					grow_token();
					lex_mode = MODE_LINE_CMT;
					taken = 1'b1;
				end else if (b == CH_STAR) begin
					grow_token();
					lex_mode  = MODE_BLOCK;
					star_prev = 1'b0;
					taken = 1'b1;
				end else
					close_token(TOK_OPERATOR);
			end
			MODE_BLOCK: begin
				grow_token();
				taken = 1'b1;
				if (star_prev && b == CH_SLASH)
					close_token(TOK_COMMENT);
				else
					star_prev = (b == CH_STAR);
			end
			MODE_STRING: begin
				grow_token();
				taken = 1'b1;
				if (escaped)
					escaped = 1'b0;
				else if (b == CH_BSLASH)
					escaped = 1'b1;
				else if (b == quote_ch)
					close_token(TOK_STRING);
			end
			MODE_NUMBER: begin
				if (cls == CL_DIGIT) begin
					got_digit = 1'b1;
					grow_token();
					taken = 1'b1;
				end else if (cls == CL_POINT && !got_point) begin
					got_point = 1'b1;
					grow_token();
					taken = 1'b1;
				end else
					close_token(got_digit ? TOK_NUMBER : TOK_UNKNOWN);
			end
			MODE_IDENT: begin
				if (cls == CL_LETTER || cls == CL_DIGIT) begin
					grow_token();
					taken = 1'b1;
				end else
					close_token(TOK_IDENT);
			end
			default: ;
		endcase
		if (!taken)
			open_token(b, cls);
		if (cls == CL_NEWLINE) begin
			if (line_no != '1)
				line_no = line_no + 1'b1;
			col_no = COL_W'(1);
		end else if (col_no != '1)
			col_no = col_no + 1'b1;
		if (eot) begin
			case (lex_mode)
				MODE_SPACE: close_token(TOK_SPACE);
				MODE_LINE_CMT, MODE_BLOCK: close_token(TOK_COMMENT);
				MODE_SLASH: close_token(TOK_OPERATOR);
				MODE_STRING: close_token(TOK_UNKNOWN);
				MODE_NUMBER: close_token(got_digit ? TOK_NUMBER : TOK_UNKNOWN);
				MODE_IDENT: close_token(TOK_IDENT);
				default: ;
			endcase
			emit(TOK_END, line_no, col_no, '0, 1'b1);
			restart_lexer();
		end
	endfunction

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(4))
			0: return 8'h20;
			1: return 8'h09;
			2: return 8'h0b;
			3: return 8'h0c;
			default: return 8'h0d;
		endcase
	endfunction

	// one mostly well-formed lexeme with random content, sometimes broken or noise
	function automatic void build_fragment();
		logic [7:0] q;
		frag.delete();
		case ($urandom_range(11))
			0: begin
				frag.push_back(pick("_abzAZq"));
				repeat ($urandom_range(5)) frag.push_back(pick("_az09AZk"));
			end
			1: begin
				if ($urandom_range(2) == 0)
					frag.push_back(pick("+-"));
				if ($urandom_range(7) == 0) begin
					// sign or point with no digit
					if ($urandom_range(1) == 0 || frag.size() == 0)
						frag.push_back(CH_POINT);
				end else begin
					repeat ($urandom_range(1, 3)) frag.push_back(pick("0123456789"));
					if ($urandom_range(1) == 0) begin
						frag.push_back(CH_POINT);
						repeat ($urandom_range(3)) frag.push_back(pick("0123456789"));
					end
				end
			end
			2: begin
				q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
				frag.push_back(q);
				repeat ($urandom_range(6)) begin
					if ($urandom_range(5) == 0) begin
						frag.push_back(CH_BSLASH);
						frag.push_back(8'($urandom_range(255)));
					end else
						frag.push_back(8'($urandom_range(32, 126)));
				end
				if ($urandom_range(5) != 0)
					frag.push_back(q);
			end
			3: begin
				if ($urandom_range(1) == 0)
					frag.push_back(CH_HASH);
				else begin
					frag.push_back(CH_SLASH);
					frag.push_back(CH_SLASH);
				end
				repeat ($urandom_range(6)) frag.push_back(8'($urandom_range(32, 126)));
				frag.push_back(CH_NL);
			end
			4: begin
				frag.push_back(CH_SLASH);
				frag.push_back(CH_STAR);
				repeat ($urandom_range(6)) frag.push_back(pick("a */\n*"));
				if ($urandom_range(5) != 0) begin
					frag.push_back(CH_STAR);
					frag.push_back(CH_SLASH);
				end
			end
			5: repeat ($urandom_range(1, 4)) frag.push_back(pick_blank());
			6: frag.push_back(CH_NL);
			7: frag.push_back(pick("*=<>!&|^%~"));
			8: frag.push_back(pick("(){}[];:,"));
			9: frag.push_back(CH_SLASH);
			default: frag.push_back(8'($urandom_range(255)));
		endcase
	endfunction

	// offers one text byte and waits for the request to be taken
	task automatic send_byte(input logic [7:0] b, input logic eot, input logic typed,
			input token_rec_t want);
		while (idle_on && $urandom_range(99) < 33) begin
			chars.valid <= 1'b0;
			@(posedge clk);
		end
		chars.valid       <= 1'b1;
		chars.text_byte   <= b;
		chars.end_of_text <= eot;
		@(posedge clk);
		while (!chars.ready)
			@(posedge clk);
		fresh_tokens.delete();
		lex_byte(b, eot);
		if (typed) begin
			fresh_tokens.delete();
			fresh_tokens.push_back(want);
		end
		foreach (fresh_tokens[i])
			expected_tokens.push_back(fresh_tokens[i]);
	endtask

	task automatic check_token();
		token_rec_t want;
		tokens_seen++;
		if (expected_tokens.size() == 0) begin
			$error("token request with nothing expected: type %0d line %0d column %0d",
				tokens.token_type, tokens.start_line, tokens.start_column);
			mismatches++;
			return;
		end
		want = expected_tokens.pop_front();
		if (tokens.token_type !== want.kind) begin
			$error("token_type: expected %0d, got %0d", want.kind, tokens.token_type);
			mismatches++;
		end
		if (tokens.start_line !== want.line) begin
			$error("start_line: expected %0d, got %0d", want.line, tokens.start_line);
			mismatches++;
		end
		if (tokens.start_column !== want.col) begin
			$error("start_column: expected %0d, got %0d", want.col, tokens.start_column);
			mismatches++;
		end
		if (tokens.token_length !== want.len) begin
			$error("token_length: expected %0d, got %0d", want.len, tokens.token_length);
			mismatches++;
		end
		if (tokens.is_last !== want.last) begin
			$error("is_last: expected %0d, got %0d", want.last, tokens.is_last);
			mismatches++;
		end
	endtask

	// token side: check, random stalls and one long hold-off while text keeps coming
	always @(posedge clk) begin
		if (tokens.valid && tokens.ready)
			check_token();
		if (hold_left != 0) begin
			hold_left--;
			tokens.ready <= 1'b0;
		end else if (!held_once && tokens_seen >= HOLD_AFTER) begin
			held_once = 1'b1;
			hold_left = HOLD_CYCLES;
			tokens.ready <= 1'b0;
		end else
			tokens.ready <= !(idle_on && $urandom_range(99) < 33);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned random_sent;
		bit end_text;
		arst_n            <= 1'b0;
		chars.valid       <= 1'b0;
		chars.text_byte   <= '0;
		chars.end_of_text <= 1'b0;
		restart_lexer();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].b, directed_rows[i].eot, directed_rows[i].typed,
				directed_rows[i].want);

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			build_fragment();
			end_text = ($urandom_range(9) == 0) || (random_sent + frag.size() >= RANDOM_ITEMS);
			foreach (frag[i])
				send_byte(frag[i], end_text && (i == frag.size() - 1), 1'b0, NO_TOKEN);
			random_sent += frag.size();
			// a calm stretch with no idling on either side
			idle_on <= !(random_sent >= 70 && random_sent < 115);
		end
		chars.valid <= 1'b0;

		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/ctl_pkg.sv
hw/rtl/ctl_if.sv
hw/rtl/ctl_lexer_core.sv
hw/rtl/ctl_result_buf.sv
hw/rtl/c_style_token_lexer_unit.sv
verif/tb_c_style_token_lexer_unit.sv
